>>> rtl/pkmil_pkg.sv
`default_nettype none

package pkmil_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned InKeyW   = 16;
  localparam int unsigned OutcomeW = 3;

  localparam logic [OutcomeW-1:0] OutExisting  = 3'd0;
  localparam logic [OutcomeW-1:0] OutAdded     = 3'd1;
  localparam logic [OutcomeW-1:0] OutTooSoon   = 3'd2;
  localparam logic [OutcomeW-1:0] OutUntracked = 3'd3;
  localparam logic [OutcomeW-1:0] OutNoKey     = 3'd4;

  localparam logic [TimeW-1:0] MinIntervalReset = 32'd1000;

  typedef struct packed {
    logic                active;
    logic                done;
    logic [OutcomeW-1:0] outcome;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/pkmil_if.sv
`default_nettype none

interface pkmil_req_if;
  logic                                valid;
  logic                                ready;
  logic                                key_present;
  logic [pkmil_pkg::InKeyW-1:0]        handler_key;
  logic [pkmil_pkg::TimeW-1:0]         now_ms;

  modport source (output valid, key_present, handler_key, now_ms, input ready);
  modport sink   (input valid, key_present, handler_key, now_ms, output ready);
endinterface

interface pkmil_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                allowed;
  logic [pkmil_pkg::OutcomeW-1:0]      outcome;

  modport source (output valid, allowed, outcome, input ready);
  modport sink   (input valid, allowed, outcome, output ready);
endinterface

`default_nettype wire

>>> rtl/pkmil_cell.sv
`default_nettype none

module pkmil_cell #(
  parameter int unsigned KeyW  = 16,
  parameter int unsigned CntW  = 5,
  parameter int unsigned Index = 0
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire [pkmil_pkg::TimeW-1:0]   min_interval_i,
  input  wire [CntW-1:0]               used_i,
  input  wire pkmil_pkg::tok_t         tok_i,
  input  wire [KeyW-1:0]               key_i,
  input  wire [pkmil_pkg::TimeW-1:0]   now_i,
  output pkmil_pkg::tok_t              tok_o,
  output logic [KeyW-1:0]              key_o,
  output logic [pkmil_pkg::TimeW-1:0]  now_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Index);

  logic [KeyW-1:0]              ent_key_q;
  logic [pkmil_pkg::TimeW-1:0]  ent_time_q;
  logic [pkmil_pkg::TimeW-1:0]  elapsed;
  logic                         live;
  logic                         match;
  logic                         claim;
  logic                         too_soon;
  pkmil_pkg::tok_t              tok_d;
  pkmil_pkg::tok_t              tok_q;
  logic [KeyW-1:0]              key_q;
  logic [pkmil_pkg::TimeW-1:0]  now_q;

  always_comb begin
    live     = tok_i.active && !tok_i.done;
    elapsed  = now_i - ent_time_q;
    too_soon = elapsed < min_interval_i;
    match    = live && (IdxC < used_i) && (ent_key_q == key_i);
    claim    = live && (IdxC == used_i);
    tok_d    = tok_i;
    if (match) begin
      tok_d.done    = 1'b1;
      tok_d.outcome = too_soon ? pkmil_pkg::OutTooSoon : pkmil_pkg::OutExisting;
    end else if (claim) begin
      tok_d.done    = 1'b1;
      tok_d.outcome = pkmil_pkg::OutAdded;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim) begin
      ent_key_q <= key_i;
    end
    if (claim || (match && !too_soon)) begin
      ent_time_q <= now_i;
    end
    key_q <= key_i;
    now_q <= now_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign key_o = key_q;
  assign now_o = now_q;

endmodule

`default_nettype wire

>>> rtl/per_key_min_interval_limiter_unit.sv
// Per-key minimum-interval limiter. A request is taken when req_i.ready is high and
// travels down a row of TABLE_ENTRIES cells, one cell per cycle; each cell holds one
// key and its last accepted time, checks and updates it, or claims itself for a new
// key when it is the first unused entry. The result then passes through a pending
// register and an output register before it appears on rsp_o. One request is in
// flight at a time; the next one can be taken as soon as the previous result has
// moved into the output register, even if that result has not yet been taken. The
// minimum interval is written through cfg_we_i and cfg_wdata_i; the user must write
// it only while no request is in flight, and the block itself does not enforce this.
// It resets to 1000 ms.
`default_nettype none

module per_key_min_interval_limiter_unit #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned KEY_BITS      = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [pkmil_pkg::TimeW-1:0]   cfg_wdata_i,
  pkmil_req_if.sink                    req_i,
  pkmil_rsp_if.source                  rsp_o
);

  localparam int unsigned KeyW = (KEY_BITS < pkmil_pkg::InKeyW) ? KEY_BITS
                                                                : pkmil_pkg::InKeyW;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] FullC = CntW'(TABLE_ENTRIES);

  pkmil_pkg::tok_t              tok   [TABLE_ENTRIES+1];
  logic [KeyW-1:0]              key   [TABLE_ENTRIES+1];
  logic [pkmil_pkg::TimeW-1:0]  now   [TABLE_ENTRIES+1];

  logic [pkmil_pkg::TimeW-1:0]  min_interval_q;
  logic [CntW-1:0]              used_q;
  logic                         busy_q;
  logic                         pend_q;
  logic [pkmil_pkg::OutcomeW-1:0] pend_outcome_q;
  logic                         out_valid_q;
  logic [pkmil_pkg::OutcomeW-1:0] out_outcome_q;
  logic                         accept;
  logic                         move;
  pkmil_pkg::tok_t              exit_tok;
  logic [pkmil_pkg::OutcomeW-1:0] exit_outcome;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = !busy_q;

  always_comb begin
    tok[0].active  = accept;
    tok[0].done    = !req_i.key_present;
    tok[0].outcome = pkmil_pkg::OutNoKey;
  end
  assign key[0] = req_i.handler_key[KeyW-1:0];
  assign now[0] = req_i.now_ms;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pkmil_cell #(
      .KeyW  (KeyW),
      .CntW  (CntW),
      .Index (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .min_interval_i (min_interval_q),
      .used_i         (used_q),
      .tok_i          (tok[g]),
      .key_i          (key[g]),
      .now_i          (now[g]),
      .tok_o          (tok[g+1]),
      .key_o          (key[g+1]),
      .now_o          (now[g+1])
    );
  end

  assign exit_tok     = tok[TABLE_ENTRIES];
  assign exit_outcome = exit_tok.done ? exit_tok.outcome : pkmil_pkg::OutUntracked;
  assign move         = pend_q && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i) begin
    if (exit_tok.active) begin
      pend_outcome_q <= exit_outcome;
    end
    if (move) begin
      out_outcome_q <= pend_outcome_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_interval_q <= pkmil_pkg::MinIntervalReset;
      used_q         <= '0;
      busy_q         <= 1'b0;
      pend_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_interval_q <= cfg_wdata_i;
      end
      if (exit_tok.active && exit_outcome == pkmil_pkg::OutAdded && used_q != FullC) begin
        used_q <= used_q + CntW'(1);
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (move) begin
        busy_q <= 1'b0;
      end
      if (exit_tok.active) begin
        pend_q <= 1'b1;
      end else if (move) begin
        pend_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.outcome = out_outcome_q;
  assign rsp_o.allowed = (out_outcome_q == pkmil_pkg::OutExisting) ||
                         (out_outcome_q == pkmil_pkg::OutAdded) ||
                         (out_outcome_q == pkmil_pkg::OutUntracked);

endmodule

`default_nettype wire

>>> rtl/pkmil_checker.sv
`default_nettype none

module pkmil_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                in_valid_i,
  input wire                                in_ready_i,
  input wire                                out_valid_i,
  input wire                                out_ready_i,
  input wire                                out_allowed_i,
  input wire [pkmil_pkg::OutcomeW-1:0]      out_outcome_i
);

  // One request in flight: the port closes right after a beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while a request is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_allowed_i == ((out_outcome_i != pkmil_pkg::OutTooSoon) &&
                                       (out_outcome_i != pkmil_pkg::OutNoKey))))
    else $error("allowed flag disagrees with outcome");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_outcome_i == pkmil_pkg::OutExisting ||
                     out_outcome_i == pkmil_pkg::OutAdded ||
                     out_outcome_i == pkmil_pkg::OutTooSoon ||
                     out_outcome_i == pkmil_pkg::OutUntracked ||
                     out_outcome_i == pkmil_pkg::OutNoKey))
    else $error("undefined outcome code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_outcome_i)))
    else $error("stalled result beat changed");

endmodule

bind per_key_min_interval_limiter_unit pkmil_checker u_pkmil_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_allowed_i (rsp_o.allowed),
  .out_outcome_i (rsp_o.outcome)
);

`default_nettype wire
